FILE: src/mqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_pkg
// Types and constants shared by the MQTT packet deframer modules.
// ----------------------------------------------------------------------------
package mqd_pkg;

    localparam int LEN_W = 28;

    localparam logic [3:0] TYPE_PUBLISH   = 4'd3;
    localparam logic [2:0] LEN_BYTES_MAX  = 3'd4;
    localparam logic [1:0] QOS_ONE        = 2'd1;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_LEN,
        PH_TLEN_HI,
        PH_TLEN_LO,
        PH_TOPIC,
        PH_ID_HI,
        PH_ID_LO,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HDR_DONE   = 3'd0,
        KIND_TOPIC_LEN  = 3'd1,
        KIND_TOPIC      = 3'd2,
        KIND_PKT_ID     = 3'd3,
        KIND_PAYLOAD    = 3'd4,
        KIND_OTHER_BODY = 3'd5,
        KIND_MALFORMED  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         packet_type;
        logic [3:0]         packet_flags;
        logic [LEN_W-1:0]   remaining_length;
        logic [7:0]         data_byte;
        logic [15:0]        msg_id;
        logic [1:0]         qos;
        logic               publish_valid;
        logic               ack_needed;
        logic               last;
    } res_t;

endpackage

FILE: src/mqd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_parse
// Packet state registers and the per-byte classification logic.
// ----------------------------------------------------------------------------
module mqd_parse
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    input  logic           restart,
    output logic           res_valid,
    output mqd_pkg::res_t  res
);
    import mqd_pkg::*;

    phase_t             phase_reg, phase_next, phase_eff, body_next;
    logic [3:0]         type_reg, type_next;
    logic [3:0]         flag_reg, flag_next;
    logic [LEN_W-1:0]   accum_reg, accum_next;
    logic [2:0]         lbs_reg, lbs_next;
    logic [LEN_W-1:0]   body_left_reg, body_left_next;
    logic [7:0]         topic_hi_reg, topic_hi_next;
    logic [15:0]        topic_left_reg, topic_left_next;
    logic [7:0]         id_high_reg, id_high_next;
    logic               err_reg, err_next, err_eff;
    logic [LEN_W-1:0]   len_part;
    logic               pub;
    logic [1:0]         qos;
    logic               hit;

    assign pub = (type_reg == TYPE_PUBLISH);
    assign qos = flag_reg[2:1];

    // Place the seven length bits at the group given by the byte count.
    always_comb
    begin
        case (lbs_reg[1:0])
            2'd0:    len_part = {21'd0, rx_byte[6:0]};
            2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
            default: len_part = {rx_byte[6:0], 21'd0};
        endcase
    end

    always_comb
    begin
        // A restart byte is parsed as if the block had just come out of reset.
        phase_eff       = restart ? PH_HDR : phase_reg;
        err_eff         = restart ? 1'b0 : err_reg;
        phase_next      = phase_eff;
        err_next        = err_eff;
        type_next       = type_reg;
        flag_next       = flag_reg;
        accum_next      = accum_reg;
        lbs_next        = lbs_reg;
        body_left_next  = body_left_reg;
        topic_hi_next   = topic_hi_reg;
        topic_left_next = topic_left_reg;
        id_high_next    = id_high_reg;
        body_next       = PH_BODY;
        hit             = 1'b0;

        res.kind             = KIND_HDR_DONE;
        res.packet_type      = type_reg;
        res.packet_flags     = flag_reg;
        res.remaining_length = accum_reg;
        res.data_byte        = 8'd0;
        res.msg_id           = 16'd0;
        res.qos              = pub ? qos : 2'd0;
        res.publish_valid    = 1'b0;
        res.ack_needed       = 1'b0;
        res.last             = 1'b0;

        if (!err_eff)
        begin
            unique case (phase_eff)
                PH_HDR:
                begin
                    type_next  = rx_byte[7:4];
                    flag_next  = rx_byte[3:0];
                    accum_next = '0;
                    lbs_next   = 3'd0;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (lbs_reg >= LEN_BYTES_MAX)
                    begin
                        err_next             = 1'b1;
                        phase_next           = PH_HDR;
                        hit                  = 1'b1;
                        res.kind             = KIND_MALFORMED;
                        res.remaining_length = '0;
                        res.last             = 1'b1;
                    end
                    else
                    begin
                        accum_next = accum_reg | len_part;
                        lbs_next   = lbs_reg + 3'd1;
                        if (!rx_byte[7])
                        begin
                            hit                  = 1'b1;
                            body_left_next       = accum_next;
                            res.remaining_length = accum_next;
                            if (accum_next == '0)
                            begin
                                phase_next = PH_HDR;
                                res.last   = 1'b1;
                            end
                            else
                            begin
                                phase_next = pub ? PH_TLEN_HI : PH_BODY;
                            end
                        end
                    end
                end
                default:
                begin
                    hit            = 1'b1;
                    body_left_next = body_left_reg - LEN_W'(1);
                    res.data_byte  = rx_byte;
                    res.last       = (body_left_next == '0);
                    unique case (phase_eff)
                        PH_TLEN_HI:
                        begin
                            res.kind      = KIND_TOPIC_LEN;
                            topic_hi_next = rx_byte;
                            body_next     = PH_TLEN_LO;
                        end
                        PH_TLEN_LO:
                        begin
                            res.kind        = KIND_TOPIC_LEN;
                            topic_left_next = {topic_hi_reg, rx_byte};
                            if (topic_left_next != 16'd0)
                                body_next = PH_TOPIC;
                            else
                                body_next = (qos != 2'd0) ? PH_ID_HI : PH_BODY;
                        end
                        PH_TOPIC:
                        begin
                            res.kind        = KIND_TOPIC;
                            topic_left_next = topic_left_reg - 16'd1;
                            if (topic_left_next != 16'd0)
                                body_next = PH_TOPIC;
                            else
                                body_next = (qos != 2'd0) ? PH_ID_HI : PH_BODY;
                        end
                        PH_ID_HI:
                        begin
                            res.kind     = KIND_PKT_ID;
                            id_high_next = rx_byte;
                            body_next    = PH_ID_LO;
                        end
                        PH_ID_LO:
                        begin
                            res.kind   = KIND_PKT_ID;
                            res.msg_id = {id_high_reg, rx_byte};
                            body_next  = PH_BODY;
                        end
                        default:
                        begin
                            res.kind  = pub ? KIND_PAYLOAD : KIND_OTHER_BODY;
                            body_next = PH_BODY;
                        end
                    endcase
                    if (res.last)
                    begin
                        res.publish_valid = pub && (body_next == PH_BODY);
                        res.ack_needed    = res.publish_valid && (qos == QOS_ONE);
                        phase_next        = PH_HDR;
                    end
                    else
                    begin
                        phase_next = body_next;
                    end
                end
            endcase
        end

        res_valid = accept && hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR;
            err_reg        <= 1'b0;
            type_reg       <= 4'd0;
            flag_reg       <= 4'd0;
            accum_reg      <= '0;
            lbs_reg        <= 3'd0;
            body_left_reg  <= '0;
            topic_hi_reg   <= 8'd0;
            topic_left_reg <= 16'd0;
            id_high_reg    <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            err_reg        <= err_next;
            type_reg       <= type_next;
            flag_reg       <= flag_next;
            accum_reg      <= accum_next;
            lbs_reg        <= lbs_next;
            body_left_reg  <= body_left_next;
            topic_hi_reg   <= topic_hi_next;
            topic_left_reg <= topic_left_next;
            id_high_reg    <= id_high_next;
        end
    end

    // After a malformed length the parser must be parked at the header phase.
    a_err_parks: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> (phase_reg == PH_HDR))
        else $error("sticky error set outside header phase");

    a_lbs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lbs_reg <= LEN_BYTES_MAX)
        else $error("length byte count exceeded four");

    a_topic_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TOPIC) |-> (topic_left_reg != 16'd0))
        else $error("topic phase with no topic bytes left");

endmodule

FILE: src/mqd_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqd_obuf
// Result register with a skid stage, so one more result is taken while output stalls.
// ----------------------------------------------------------------------------
module mqd_obuf
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mqd_pkg::res_t  push_data,
    output logic           push_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output mqd_pkg::res_t  out_data
);
    import mqd_pkg::*;

    res_t  out_reg;
    res_t  skid_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;
    logic  pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while output register is empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed while both stages are full");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid stage filled without an output stall");

endmodule

FILE: src/mqtt_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqtt_packet_deframer
// MQTT 3.1.1 receive-side splitter: fixed header, length and PUBLISH fields.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock while in_ready is high; the parse logic is combinational.
// Each result is registered in the buffer's output register, or in its skid stage while the output stalls.
// A two-entry result buffer keeps input flowing during an output stall until its skid entry fills.
// Reset (rst_n, asynchronous) returns the parser to waiting for a header byte
// and empties the result buffer.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   rx_byte,
    input  logic         restart,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   kind,
    output logic [3:0]   packet_type,
    output logic [3:0]   packet_flags,
    output logic [27:0]  remaining_length,
    output logic [7:0]   data_byte,
    output logic [15:0]  msg_id,
    output logic [1:0]   qos,
    output logic         publish_valid,
    output logic         ack_needed,
    output logic         last
);
    import mqd_pkg::*;

    logic  accept;
    logic  res_valid;
    res_t  res;
    res_t  out_data;

    assign accept = in_valid && in_ready;

    mqd_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .restart   (restart),
        .res_valid (res_valid),
        .res       (res)
    );

    mqd_obuf u_obuf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign kind             = 3'(out_data.kind);
    assign packet_type      = out_data.packet_type;
    assign packet_flags     = out_data.packet_flags;
    assign remaining_length = out_data.remaining_length;
    assign data_byte        = out_data.data_byte;
    assign msg_id           = out_data.msg_id;
    assign qos              = out_data.qos;
    assign publish_valid    = out_data.publish_valid;
    assign ack_needed       = out_data.ack_needed;
    assign last             = out_data.last;

endmodule
